// ===== design/amon_pkg.sv =====
package amon_pkg;

   typedef enum logic [1:0] {
      CLS_IDLE = 2'd0,
      CLS_DOOR = 2'd1,
      CLS_RUN  = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      LED_BLUE   = 2'd0,
      LED_YELLOW = 2'd1,
      LED_RED    = 2'd2,
      LED_BLINK  = 2'd3
   } led_type;

   localparam int unsigned ADDR_W = 5;

   localparam logic [2:0] REG_RUN_THRESHOLD  = 3'd0;
   localparam logic [2:0] REG_OPEN_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_SETTLE_TICKS   = 3'd2;
   localparam logic [2:0] REG_FOOD_INTERVAL  = 3'd3;
   localparam logic [2:0] REG_DOOR_INTERVAL  = 3'd4;

   localparam logic [15:0] RST_RUN_THRESHOLD  = 16'd300;
   localparam logic [15:0] RST_OPEN_THRESHOLD = 16'd50;
   localparam logic [7:0]  RST_SETTLE_TICKS   = 8'd7;
   localparam logic [15:0] RST_FOOD_INTERVAL  = 16'd100;
   localparam logic [15:0] RST_DOOR_INTERVAL  = 16'd300;

   localparam logic [7:0] DWELL_MAX = 8'hFF;

   typedef struct packed {
      logic [15:0] run_threshold;
      logic [15:0] open_threshold;
      logic [7:0]  settle_ticks;
      logic [15:0] food_alert_interval;
      logic [15:0] door_alert_interval;
   } cfg_type;

   typedef struct packed {
      class_type oven_state;
      led_type   led_code;
      logic      food_present;
      logic      food_alert;
      logic      door_alert;
      logic      food_removed;
   } result_type;

endpackage

// ===== design/amon_step.sv =====
module amon_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [15:0]          sample,
   input  amon_pkg::cfg_type    cfg,
   output amon_pkg::result_type result
);

   amon_pkg::class_type last_class_ff, last_class_in;
   logic [7:0]          dwell_ff, dwell_in;
   logic [1:0]          blink_ff, blink_in;
   logic [15:0]         food_phase_ff, food_phase_in;
   logic [15:0]         door_phase_ff, door_phase_in;
   logic                food_flag_ff, food_flag_in;

   amon_pkg::class_type cls;
   amon_pkg::led_type   led;
   logic                same;
   logic [7:0]          dwell_inc;
   logic                settle_hit;
   logic                removed;
   logic [16:0]         food_sum;
   logic [16:0]         door_sum;
   logic                food_wrap;
   logic                door_wrap;
   logic                blink_now;

   always_comb begin
      if (sample > cfg.run_threshold) begin
         cls = amon_pkg::CLS_RUN;
      end else if (sample > cfg.open_threshold) begin
         cls = amon_pkg::CLS_DOOR;
      end else begin
         cls = amon_pkg::CLS_IDLE;
      end

      same      = (cls == last_class_ff);
      dwell_inc = dwell_ff + 8'd1;
      // settle fires only on the step that lands exactly on settle_ticks
      settle_hit = same && (dwell_ff != amon_pkg::DWELL_MAX) && (dwell_inc == cfg.settle_ticks);

      food_sum  = {1'b0, food_phase_ff} + 17'd1;
      door_sum  = {1'b0, door_phase_ff} + 17'd1;
      food_wrap = (food_sum >= {1'b0, cfg.food_alert_interval});
      door_wrap = (door_sum >= {1'b0, cfg.door_alert_interval});

      last_class_in = cls;
      food_flag_in  = food_flag_ff;
      removed       = 1'b0;
      if (settle_hit && cls == amon_pkg::CLS_RUN) begin
         food_flag_in = 1'b1;
      end
      if (settle_hit && cls == amon_pkg::CLS_DOOR && food_flag_ff) begin
         food_flag_in = 1'b0;
         removed      = 1'b1;
      end

      if (same) begin
         dwell_in      = (dwell_ff == amon_pkg::DWELL_MAX) ? dwell_ff : dwell_inc;
         blink_in      = blink_ff + 2'd1;
         food_phase_in = food_wrap ? 16'd0 : food_sum[15:0];
         door_phase_in = door_wrap ? 16'd0 : door_sum[15:0];
      end else begin
         dwell_in      = 8'd0;
         blink_in      = 2'd0;
         food_phase_in = 16'd0;
         door_phase_in = 16'd0;
      end
      blink_now = same && (blink_in == 2'd0);

      case (cls)
         amon_pkg::CLS_RUN:  led = amon_pkg::LED_RED;
         amon_pkg::CLS_DOOR: led = amon_pkg::LED_YELLOW;
         default:            led = amon_pkg::LED_BLUE;
      endcase
      if (cls == amon_pkg::CLS_IDLE && food_flag_in && blink_now) begin
         led = amon_pkg::LED_BLINK;
      end

      result.oven_state   = cls;
      result.led_code     = led;
      result.food_present = food_flag_in;
      result.food_alert   = same && cls == amon_pkg::CLS_IDLE && food_flag_in && food_wrap;
      result.door_alert   = same && cls == amon_pkg::CLS_DOOR && door_wrap;
      result.food_removed = removed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_class_ff <= amon_pkg::CLS_IDLE;
         dwell_ff      <= 8'd0;
         blink_ff      <= 2'd0;
         food_phase_ff <= 16'd0;
         door_phase_ff <= 16'd0;
         food_flag_ff  <= 1'b0;
      end else if (advance) begin
         last_class_ff <= last_class_in;
         dwell_ff      <= dwell_in;
         blink_ff      <= blink_in;
         food_phase_ff <= food_phase_in;
         door_phase_ff <= door_phase_in;
         food_flag_ff  <= food_flag_in;
      end
   end

   // a class change restarts the dwell count
   a_dwell_restart: assert property (@(posedge clock) disable iff (reset)
      advance && !same |=> dwell_ff == 8'd0)
      else $error("dwell count not cleared on class change");

   // food flag can only rise while running
   a_flag_rise: assert property (@(posedge clock) disable iff (reset)
      advance && !food_flag_ff && food_flag_in |-> cls == amon_pkg::CLS_RUN)
      else $error("food flag set outside running class");

endmodule

// ===== design/appliance_current_state_monitor_top.sv =====
// Appliance current monitor: classifies one 16-bit current sample per request
// as running, door open or idle against two programmable strict thresholds,
// tracks a food flag through settle counts and raises blink, food-left and
// door-open indications. Throughput is one request per clock while rsp_ready
// stays high; a request's response passes the input register, then the result
// register, with all class, dwell and phase updates done in the single
// combinational step between them. A response holds while rsp_ready is low, and
// req_ready drops while both registers are full and rsp_ready is low.
// Configuration registers sit at byte addresses 0x00..0x10 and should be
// written only while no request is in flight.
module appliance_current_state_monitor_top (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [15:0]               req_current_sample,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_oven_state,
   output logic [1:0]                rsp_led_code,
   output logic                      rsp_food_present,
   output logic                      rsp_food_alert,
   output logic                      rsp_door_alert,
   output logic                      rsp_food_removed,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [amon_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   amon_pkg::cfg_type    cfg_ff;
   logic                 in_valid_ff;
   logic [15:0]          sample_ff;
   logic                 rsp_valid_ff;
   amon_pkg::result_type res_ff;
   amon_pkg::result_type res_in;
   logic                 out_free;
   logic                 advance;
   logic                 cfg_write;
   logic [2:0]           reg_index;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign reg_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_threshold       <= amon_pkg::RST_RUN_THRESHOLD;
         cfg_ff.open_threshold      <= amon_pkg::RST_OPEN_THRESHOLD;
         cfg_ff.settle_ticks        <= amon_pkg::RST_SETTLE_TICKS;
         cfg_ff.food_alert_interval <= amon_pkg::RST_FOOD_INTERVAL;
         cfg_ff.door_alert_interval <= amon_pkg::RST_DOOR_INTERVAL;
      end else if (cfg_write) begin
         case (reg_index)
            amon_pkg::REG_RUN_THRESHOLD:  cfg_ff.run_threshold       <= pwdata[15:0];
            amon_pkg::REG_OPEN_THRESHOLD: cfg_ff.open_threshold      <= pwdata[15:0];
            amon_pkg::REG_SETTLE_TICKS:   cfg_ff.settle_ticks        <= pwdata[7:0];
            amon_pkg::REG_FOOD_INTERVAL:  cfg_ff.food_alert_interval <= pwdata[15:0];
            amon_pkg::REG_DOOR_INTERVAL:  cfg_ff.door_alert_interval <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         amon_pkg::REG_RUN_THRESHOLD:  prdata = {16'd0, cfg_ff.run_threshold};
         amon_pkg::REG_OPEN_THRESHOLD: prdata = {16'd0, cfg_ff.open_threshold};
         amon_pkg::REG_SETTLE_TICKS:   prdata = {24'd0, cfg_ff.settle_ticks};
         amon_pkg::REG_FOOD_INTERVAL:  prdata = {16'd0, cfg_ff.food_alert_interval};
         amon_pkg::REG_DOOR_INTERVAL:  prdata = {16'd0, cfg_ff.door_alert_interval};
         default:                      prdata = 32'd0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_current_sample;
      end
   end

   amon_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (sample_ff),
      .cfg     (cfg_ff),
      .result  (res_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_oven_state   = res_ff.oven_state;
   assign rsp_led_code     = res_ff.led_code;
   assign rsp_food_present = res_ff.food_present;
   assign rsp_food_alert   = res_ff.food_alert;
   assign rsp_door_alert   = res_ff.door_alert;
   assign rsp_food_removed = res_ff.food_removed;

   a_removed_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.food_removed |->
         !res_ff.food_present && res_ff.oven_state == amon_pkg::CLS_DOOR)
      else $error("removal reported with food still flagged");

   a_food_alert_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.food_alert |->
         res_ff.food_present && res_ff.oven_state == amon_pkg::CLS_IDLE)
      else $error("food alert outside idle with food");

   a_door_alert_door: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.door_alert |-> res_ff.oven_state == amon_pkg::CLS_DOOR)
      else $error("door alert outside door-open class");

   a_blink_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.led_code == amon_pkg::LED_BLINK |->
         res_ff.food_present && res_ff.oven_state == amon_pkg::CLS_IDLE)
      else $error("blink shown outside idle with food");

endmodule

// ===== sim/appliance_current_state_monitor_top_tb.sv =====
`timescale 1ns / 100ps

module appliance_current_state_monitor_top_tb;

   localparam logic [2:0] REG_UNUSED = 3'd5;

   localparam int READY_ALWAYS = 0;
   localparam int READY_HALF   = 1;
   localparam int READY_SPARSE = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_current_sample = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_oven_state;
   logic [1:0]  rsp_led_code;
   logic        rsp_food_present;
   logic        rsp_food_alert;
   logic        rsp_door_alert;
   logic        rsp_food_removed;

   logic                        psel    = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite  = 1'b0;
   logic [amon_pkg::ADDR_W-1:0] paddr   = '0;
   logic [31:0]                 pwdata  = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   appliance_current_state_monitor_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_current_sample (req_current_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_oven_state     (rsp_oven_state),
      .rsp_led_code       (rsp_led_code),
      .rsp_food_present   (rsp_food_present),
      .rsp_food_alert     (rsp_food_alert),
      .rsp_door_alert     (rsp_door_alert),
      .rsp_food_removed   (rsp_food_removed),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #10 clock = ~clock;

   // shadow of the block's registers and tracking state
   amon_pkg::cfg_type   trk_cfg;
   amon_pkg::class_type trk_class;
   logic [7:0]          trk_dwell;
   logic [1:0]          trk_blink;
   logic [15:0]         trk_food_phase;
   logic [15:0]         trk_door_phase;
   logic                trk_food;

   logic [15:0]          sample_queue[$];
   amon_pkg::result_type status_expected[$];
   amon_pkg::result_type want;

   int error_count    = 0;
   int accepted_count = 0;
   int received_count = 0;
   int phase_count    = 0;

   int burst_left = 0;
   int gap_left   = 0;
   int stall_mode = READY_ALWAYS;
   int mode_left  = 0;
   int hold_left  = 0;
   bit long_hold_done = 1'b0;

   // returns {wrap, next phase}
   function automatic logic [16:0] phase_step(input logic [15:0] ph, input logic [15:0] intv);
      logic [16:0] nxt;
      nxt = {1'b0, ph} + 17'd1;
      if (nxt >= {1'b0, intv})
         return {1'b1, 16'd0};
      return {1'b0, nxt[15:0]};
   endfunction

   task automatic predict_status(input logic [15:0] sample);
      amon_pkg::result_type r;
      amon_pkg::class_type  cls;
      logic [16:0]          fstep;
      logic [16:0]          dstep;
      r = '0;
      if (sample > trk_cfg.run_threshold) begin
         cls = amon_pkg::CLS_RUN;
         r.led_code = amon_pkg::LED_RED;
      end else if (sample > trk_cfg.open_threshold) begin
         cls = amon_pkg::CLS_DOOR;
         r.led_code = amon_pkg::LED_YELLOW;
      end else begin
         cls = amon_pkg::CLS_IDLE;
         r.led_code = amon_pkg::LED_BLUE;
      end
      if (cls == trk_class) begin
         if (trk_dwell != amon_pkg::DWELL_MAX) begin
            trk_dwell = trk_dwell + 8'd1;
            if (trk_dwell == trk_cfg.settle_ticks) begin
               if (cls == amon_pkg::CLS_RUN)
                  trk_food = 1'b1;
               if (cls == amon_pkg::CLS_DOOR && trk_food) begin
                  trk_food = 1'b0;
                  r.food_removed = 1'b1;
               end
            end
         end
         trk_blink = trk_blink + 2'd1;
         fstep = phase_step(trk_food_phase, trk_cfg.food_alert_interval);
         dstep = phase_step(trk_door_phase, trk_cfg.door_alert_interval);
         trk_food_phase = fstep[15:0];
         trk_door_phase = dstep[15:0];
         if (cls == amon_pkg::CLS_IDLE && trk_food) begin
            if (trk_blink == 2'd0)
               r.led_code = amon_pkg::LED_BLINK;
            r.food_alert = fstep[16];
         end else if (cls == amon_pkg::CLS_DOOR) begin
            r.door_alert = dstep[16];
         end
      end else begin
         trk_class      = cls;
         trk_dwell      = '0;
         trk_blink      = '0;
         trk_food_phase = '0;
         trk_door_phase = '0;
      end
      r.oven_state   = cls;
      r.food_present = trk_food;
      status_expected.push_back(r);
   endtask

   // request driver: bursts of random length, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_status(req_current_sample);
            accepted_count++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left != 0 || sample_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left != 0)
                  gap_left--;
            end else begin
               req_valid <= 1'b1;
               req_current_sample <= sample_queue.pop_front();
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received_count++;
            if (status_expected.size() == 0) begin
               $error("unexpected response: state %0d led %0d", rsp_oven_state, rsp_led_code);
               error_count++;
            end else begin
               want = status_expected.pop_front();
               if (rsp_oven_state !== want.oven_state) begin
                  $error("oven_state: expected %0d, got %0d", want.oven_state, rsp_oven_state);
                  error_count++;
               end
               if (rsp_led_code !== want.led_code) begin
                  $error("led_code: expected %0d, got %0d", want.led_code, rsp_led_code);
                  error_count++;
               end
               if (rsp_food_present !== want.food_present) begin
                  $error("food_present: expected %0d, got %0d",
                         want.food_present, rsp_food_present);
                  error_count++;
               end
               if (rsp_food_alert !== want.food_alert) begin
                  $error("food_alert: expected %0d, got %0d", want.food_alert, rsp_food_alert);
                  error_count++;
               end
               if (rsp_door_alert !== want.door_alert) begin
                  $error("door_alert: expected %0d, got %0d", want.door_alert, rsp_door_alert);
                  error_count++;
               end
               if (rsp_food_removed !== want.food_removed) begin
                  $error("food_removed: expected %0d, got %0d",
                         want.food_removed, rsp_food_removed);
                  error_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && received_count >= 400) begin
            // long back-pressure so the pipeline fills and req_ready drops
            long_hold_done = 1'b1;
            hold_left = 120;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
               mode_left = $urandom_range(20, 150);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         amon_pkg::REG_RUN_THRESHOLD:  trk_cfg.run_threshold       = data[15:0];
         amon_pkg::REG_OPEN_THRESHOLD: trk_cfg.open_threshold      = data[15:0];
         amon_pkg::REG_SETTLE_TICKS:   trk_cfg.settle_ticks        = data[7:0];
         amon_pkg::REG_FOOD_INTERVAL:  trk_cfg.food_alert_interval = data[15:0];
         amon_pkg::REG_DOOR_INTERVAL:  trk_cfg.door_alert_interval = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] run_th, input logic [15:0] open_th,
                             input logic [7:0] settle, input logic [15:0] food_iv,
                             input logic [15:0] door_iv);
      csr_write(amon_pkg::REG_RUN_THRESHOLD, {16'd0, run_th});
      csr_write(amon_pkg::REG_OPEN_THRESHOLD, {16'd0, open_th});
      csr_write(amon_pkg::REG_SETTLE_TICKS, {24'd0, settle});
      csr_write(amon_pkg::REG_FOOD_INTERVAL, {16'd0, food_iv});
      csr_write(amon_pkg::REG_DOOR_INTERVAL, {16'd0, door_iv});
   endtask

   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_valid || status_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      phase_count++;
   endtask

   function automatic logic [15:0] pick_sample(input amon_pkg::class_type c);
      int unsigned run_th;
      int unsigned open_th;
      int unsigned lim;
      run_th  = trk_cfg.run_threshold;
      open_th = trk_cfg.open_threshold;
      case (c)
         amon_pkg::CLS_RUN: begin
            if (run_th == 65535)
               return 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0)
               return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'(run_th + 1);
            return 16'($urandom_range(run_th + 1, 65535));
         end
         amon_pkg::CLS_DOOR: begin
            if (open_th >= run_th)
               return 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0)
               return ($urandom_range(0, 1) != 0) ? 16'(run_th) : 16'(open_th + 1);
            return 16'($urandom_range(open_th + 1, run_th));
         end
         default: begin
            lim = (open_th < run_th) ? open_th : run_th;
            if ($urandom_range(0, 3) == 0)
               return ($urandom_range(0, 1) != 0) ? 16'(lim) : 16'd0;
            return 16'($urandom_range(0, lim));
         end
      endcase
   endfunction

   // stays in one class for a while so dwell, settle and alert intervals get exercised
   task automatic queue_segments(input int n_items, input int long_len);
      amon_pkg::class_type cls;
      int len;
      int n;
      n = 0;
      while (n < n_items) begin
         cls = amon_pkg::class_type'($urandom_range(0, 2));
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, long_len)
                                           : $urandom_range(1, 12);
         repeat (len) begin
            if ($urandom_range(0, 99) < 8)
               sample_queue.push_back(16'($urandom_range(0, 65535)));
            else
               sample_queue.push_back(pick_sample(cls));
            n++;
         end
      end
   endtask

   initial begin
      int unsigned run_th;
      trk_cfg.run_threshold       = amon_pkg::RST_RUN_THRESHOLD;
      trk_cfg.open_threshold      = amon_pkg::RST_OPEN_THRESHOLD;
      trk_cfg.settle_ticks        = amon_pkg::RST_SETTLE_TICKS;
      trk_cfg.food_alert_interval = amon_pkg::RST_FOOD_INTERVAL;
      trk_cfg.door_alert_interval = amon_pkg::RST_DOOR_INTERVAL;
      trk_class      = amon_pkg::CLS_IDLE;
      trk_dwell      = '0;
      trk_blink      = '0;
      trk_food_phase = '0;
      trk_door_phase = '0;
      trk_food       = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // threshold edges, then run to settle, idle to blink, door to remove food
      sample_queue.push_back(16'hFFFF);
      sample_queue.push_back(16'd300);
      sample_queue.push_back(16'd301);
      sample_queue.push_back(16'd50);
      sample_queue.push_back(16'd51);
      for (int i = 0; i < 8; i++)
         sample_queue.push_back((i % 2) ? 16'hFFFF : 16'd301);
      for (int i = 0; i < 5; i++)
         sample_queue.push_back((i % 2) ? 16'd50 : 16'd0);
      for (int i = 0; i < 8; i++)
         sample_queue.push_back((i % 2) ? 16'd300 : 16'd51);
      wait_idle();

      set_config(16'd300, 16'd50, 8'd3, 16'd5, 16'd4);
      queue_segments(250, 40);
      wait_idle();

      set_config(16'd1000, 16'd10, 8'd1, 16'd1, 16'd1);
      queue_segments(250, 30);
      wait_idle();

      // running unreachable, long door stay saturates the dwell count
      set_config(16'hFFFF, 16'd0, 8'd255, 16'hFFFF, 16'hFFFF);
      repeat (300) sample_queue.push_back(pick_sample(amon_pkg::CLS_DOOR));
      queue_segments(250, 300);
      wait_idle();

      // thresholds out of order, zero intervals, write to unmapped index
      set_config(16'd0, 16'hFFFF, 8'd2, 16'd0, 16'd0);
      csr_write(REG_UNUSED, $urandom);
      queue_segments(250, 60);
      wait_idle();

      // settle of zero never sets the flag
      run_th = $urandom_range(100, 65000);
      set_config(16'(run_th), 16'($urandom_range(0, run_th - 1)), 8'd0, 16'd7, 16'd3);
      queue_segments(250, 40);
      wait_idle();

      run_th = $urandom_range(200, 60000);
      set_config(16'(run_th), 16'($urandom_range(0, run_th - 1)), 8'($urandom_range(1, 12)),
                 16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)));
      queue_segments(250, 50);
      wait_idle();

      repeat (10) @(posedge clock);
      $display("Sent %0d current samples and checked %0d status responses", accepted_count,
               received_count);
      $display("across %0d register settings, with %0d mismatches", phase_count, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Timeout with %0d responses still outstanding", status_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/amon_pkg.sv
design/amon_step.sv
design/appliance_current_state_monitor_top.sv
sim/appliance_current_state_monitor_top_tb.sv
